### sv/jpeg_marker_walker_core_assert.svh
// Assertion macros shared by the marker walker modules.
`ifndef JPEG_MARKER_WALKER_CORE_ASSERT_SVH
`define JPEG_MARKER_WALKER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked at every clock edge out of reset.
`define JMW_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("jpeg marker walker check failed");
// Next-cycle implication, checked at every clock edge out of reset.
`define JMW_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("jpeg marker walker check failed");
`else
`define JMW_ASSERT_NOW(label, ante, cons)
`define JMW_ASSERT_NEXT(label, ante, cons)
`endif
`endif

### sv/jmw_pkg.sv
// Shared types, codes and marker helpers for the JPEG marker walker.
package jmw_pkg;

    // Walker phase codes.
    localparam logic [3:0] PH_SIG0    = 4'd0;
    localparam logic [3:0] PH_SIG1    = 4'd1;
    localparam logic [3:0] PH_SIG2    = 4'd2;
    localparam logic [3:0] PH_PREFIX  = 4'd3;
    localparam logic [3:0] PH_FILL    = 4'd4;
    localparam logic [3:0] PH_LEN_HI  = 4'd5;
    localparam logic [3:0] PH_LEN_LO  = 4'd6;
    localparam logic [3:0] PH_BODY    = 4'd7;
    localparam logic [3:0] PH_ENTROPY = 4'd8;
    localparam logic [3:0] PH_DONE    = 4'd9;
    localparam logic [3:0] PH_FAILED  = 4'd10;
    localparam logic [3:0] PH_REJECT  = 4'd11;

    // Marker and byte codes.
    localparam logic [7:0] MK_FF   = 8'hff;
    localparam logic [7:0] MK_SOI  = 8'hd8;
    localparam logic [7:0] MK_EOI  = 8'hd9;
    localparam logic [7:0] MK_SOS  = 8'hda;
    localparam logic [7:0] MK_SOF0 = 8'hc0;
    localparam logic [7:0] MK_SOFF = 8'hcf;
    localparam logic [7:0] MK_DHT  = 8'hc4;
    localparam logic [7:0] MK_JPG  = 8'hc8;
    localparam logic [7:0] MK_DAC  = 8'hcc;
    localparam logic [7:0] MK_RST0 = 8'hd0;
    localparam logic [7:0] MK_RST7 = 8'hd7;
    localparam logic [7:0] MK_TEM  = 8'h01;
    localparam logic [7:0] MK_NUL  = 8'h00;

    // Smallest legal segment length (the length field counts itself).
    localparam logic [15:0] LEN_MIN = 16'd2;

    // Body byte counter saturates once the frame header holds the dimensions.
    localparam logic [2:0] CNT_SAT = 3'd5;

    // One byte handed from the input register to the walker.
    typedef struct packed {
        logic       fire;
        logic [7:0] data;
        logic       last;
    } byte_item_t;

    // One result item.
    typedef struct packed {
        logic        recognized;
        logic        size_found;
        logic [15:0] width;
        logic [15:0] height;
        logic        complete;
    } result_t;

    function automatic logic is_restart(input logic [7:0] m);
        return m inside {[MK_RST0:MK_RST7]};
    endfunction

    function automatic logic is_frame_marker(input logic [7:0] m);
        return (m inside {[MK_SOF0:MK_SOFF]}) && !(m inside {MK_DHT, MK_JPG, MK_DAC});
    endfunction

endpackage

### sv/jpeg_marker_walker_core.sv
// Top level of the JPEG marker walker: input register, walker, result register.
//
//  channel | handshake           | payload
//  --------+---------------------+---------------------------------------------
//  in      | in_valid / in_stall | data_byte[7:0], last_byte
//  out     | out_valid/out_stall | recognized, size_found, width, height, complete
//
// One byte is taken per cycle unless the input stalls; the walker computes its next state combinationally.
// A result is loaded into the result register when its final byte moves on from the input register.
// The input stalls only when a final byte is held while the previous result waits.
// Reset (rst_n low, asynchronous) empties both registers and starts a new buffer.
`include "jpeg_marker_walker_core_assert.svh"
module jpeg_marker_walker_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        recognized,
    output logic        size_found,
    output logic [15:0] width,
    output logic [15:0] height,
    output logic        complete
);
    import jmw_pkg::*;

    byte_item_t item;
    result_t    result;
    logic       out_busy;

    jmw_in_stage u_in (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .out_busy  (out_busy),
        .item      (item)
    );

    jmw_parser u_parser (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .result (result)
    );

    jmw_out_stage u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (item.fire && item.last),
        .result     (result),
        .out_busy   (out_busy),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .recognized (recognized),
        .size_found (size_found),
        .width      (width),
        .height     (height),
        .complete   (complete)
    );

    // A final byte that moves on always produces a result next cycle.
    `JMW_ASSERT_NEXT(a_last_gives_result, item.fire && item.last, out_valid)
    // Input back-pressure comes only from a final byte blocked by a waiting result.
    `JMW_ASSERT_NOW(a_stall_cause, in_stall, item.last && out_valid && out_stall)
    // A blocked final byte is never processed.
    `JMW_ASSERT_NOW(a_no_fire_blocked, in_stall, !item.fire)

endmodule

### sv/jmw_in_stage.sv
// Input register of the marker walker: takes one byte item per cycle unless a held final byte stalls it.
module jmw_in_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         data_byte,
    input  logic               last_byte,
    input  logic               out_busy,
    output jmw_pkg::byte_item_t item
);
    import jmw_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] data_reg;
    logic       last_reg;
    logic       fire;
    logic       accept;

    // A held byte moves on unless it is a final byte and the result slot is stuck.
    assign fire     = valid_reg && !(last_reg && out_busy);
    assign in_stall = valid_reg && !fire;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (fire)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            data_reg <= data_byte;
            last_reg <= last_byte;
        end
    end

    assign item.fire = fire;
    assign item.data = data_reg;
    assign item.last = last_reg;

endmodule

### sv/jmw_parser.sv
// Marker segment walker state and its per-byte update.
`include "jpeg_marker_walker_core_assert.svh"
module jmw_parser (
    input  logic                clk,
    input  logic                rst_n,
    input  jmw_pkg::byte_item_t item,
    output jmw_pkg::result_t    result
);
    import jmw_pkg::*;

    logic [3:0]  phase_reg, phase_next;
    logic [15:0] len_reg, len_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic [7:0]  marker_reg, marker_next;
    logic        scan_reg, scan_next;
    logic        over_reg, over_next;
    logic [15:0] height_reg, height_next;
    logic [15:0] width_reg, width_next;
    logic        size_reg, size_next;
    logic        failed_reg, failed_next;
    logic        end_reg, end_next;
    logic        escape_reg, escape_next;

    logic        do_fail;
    logic        do_take;
    logic        do_end;
    logic [15:0] len_full;
    logic [7:0]  b;
    logic        recog;

    assign b        = item.data;
    assign len_full = {len_reg[15:8], b};

    // Per-byte walk: phase step first, then marker, segment-end and malformation handling.
    always_comb
    begin
        phase_next  = phase_reg;
        len_next    = len_reg;
        cnt_next    = cnt_reg;
        marker_next = marker_reg;
        scan_next   = scan_reg;
        over_next   = over_reg;
        height_next = height_reg;
        width_next  = width_reg;
        size_next   = size_reg;
        failed_next = failed_reg;
        end_next    = end_reg;
        escape_next = escape_reg;
        do_fail     = 1'b0;
        do_take     = 1'b0;
        do_end      = 1'b0;

        if (item.fire)
        begin
            case (phase_reg)
                PH_SIG0:
                begin
                    phase_next = (b == MK_FF) ? PH_SIG1 : PH_REJECT;
                end
                PH_SIG1:
                begin
                    phase_next = (b == MK_SOI) ? PH_SIG2 : PH_REJECT;
                end
                PH_SIG2:
                begin
                    phase_next = (b == MK_FF) ? PH_FILL : PH_REJECT;
                end
                PH_PREFIX:
                begin
                    if (b == MK_FF)
                    begin
                        phase_next = PH_FILL;
                    end
                    else
                    begin
                        do_fail = 1'b1;
                    end
                end
                PH_FILL:
                begin
                    do_take = (b != MK_FF);
                end
                PH_LEN_HI:
                begin
                    len_next   = {b, 8'h00};
                    phase_next = PH_LEN_LO;
                end
                PH_LEN_LO:
                begin
                    if (len_full < LEN_MIN)
                    begin
                        do_fail = 1'b1;
                    end
                    else
                    begin
                        len_next = len_full - LEN_MIN;
                        cnt_next = '0;
                        if (len_full == LEN_MIN)
                        begin
                            do_end = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_BODY;
                        end
                    end
                end
                PH_BODY:
                begin
                    // Frame header: height then width, both big-endian.
                    if (is_frame_marker(marker_reg) && !over_reg)
                    begin
                        case (cnt_reg)
                            3'd1:    height_next = {b, 8'h00};
                            3'd2:    height_next = {height_reg[15:8], b};
                            3'd3:    width_next  = {b, 8'h00};
                            3'd4:    width_next  = {width_reg[15:8], b};
                            default: ;
                        endcase
                    end
                    cnt_next = (cnt_reg == CNT_SAT) ? CNT_SAT : cnt_reg + 3'd1;
                    len_next = len_reg - 16'd1;
                    do_end   = (len_reg == 16'd1);
                end
                PH_ENTROPY:
                begin
                    if (!escape_reg)
                    begin
                        escape_next = (b == MK_FF);
                    end
                    else if ((b == MK_NUL) || is_restart(b))
                    begin
                        escape_next = 1'b0;
                    end
                    else if (b != MK_FF)
                    begin
                        escape_next = 1'b0;
                        do_take     = 1'b1;
                    end
                end
                default: ;
            endcase
        end

        // Marker code after the prefix and any fill bytes.
        if (do_take)
        begin
            if (b == MK_NUL)
            begin
                do_fail = 1'b1;
            end
            else if (b == MK_EOI)
            begin
                end_next   = 1'b1;
                over_next  = 1'b1;
                phase_next = PH_DONE;
            end
            else if ((b == MK_TEM) || is_restart(b))
            begin
                phase_next = PH_PREFIX;
            end
            else
            begin
                if (b == MK_SOS)
                begin
                    over_next = 1'b1;
                end
                marker_next = b;
                phase_next  = PH_LEN_HI;
            end
        end

        // Segment end: settle the frame size, then enter scan data or the next marker.
        if (do_end)
        begin
            if (is_frame_marker(marker_reg) && !over_next)
            begin
                if (cnt_next >= CNT_SAT)
                begin
                    size_next = 1'b1;
                end
                over_next = 1'b1;
            end
            if (marker_reg == MK_SOS)
            begin
                scan_next   = 1'b1;
                escape_next = 1'b0;
                phase_next  = PH_ENTROPY;
            end
            else
            begin
                phase_next = PH_PREFIX;
            end
        end

        // Malformation stops the walk.
        if (do_fail)
        begin
            failed_next = 1'b1;
            over_next   = 1'b1;
            phase_next  = PH_FAILED;
        end
    end

    // Result as seen right after the final byte.
    assign recog = (phase_next != PH_SIG0) && (phase_next != PH_SIG1)
        && (phase_next != PH_SIG2) && (phase_next != PH_REJECT);
    assign result.recognized = recog;
    assign result.size_found = recog && size_next;
    assign result.width      = (recog && size_next) ? width_next : 16'd0;
    assign result.height     = (recog && size_next) ? height_next : 16'd0;
    assign result.complete   = recog && end_next && scan_next && !failed_next;

    // State registers; the final byte returns the walker to its start.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_SIG0;
            len_reg    <= '0;
            cnt_reg    <= '0;
            marker_reg <= '0;
            scan_reg   <= 1'b0;
            over_reg   <= 1'b0;
            height_reg <= '0;
            width_reg  <= '0;
            size_reg   <= 1'b0;
            failed_reg <= 1'b0;
            end_reg    <= 1'b0;
            escape_reg <= 1'b0;
        end
        else if (item.fire && item.last)
        begin
            phase_reg  <= PH_SIG0;
            len_reg    <= '0;
            cnt_reg    <= '0;
            marker_reg <= '0;
            scan_reg   <= 1'b0;
            over_reg   <= 1'b0;
            height_reg <= '0;
            width_reg  <= '0;
            size_reg   <= 1'b0;
            failed_reg <= 1'b0;
            end_reg    <= 1'b0;
            escape_reg <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            len_reg    <= len_next;
            cnt_reg    <= cnt_next;
            marker_reg <= marker_next;
            scan_reg   <= scan_next;
            over_reg   <= over_next;
            height_reg <= height_next;
            width_reg  <= width_next;
            size_reg   <= size_next;
            failed_reg <= failed_next;
            end_reg    <= end_next;
            escape_reg <= escape_next;
        end
    end

    // A size is only ever settled once the search is closed.
    `JMW_ASSERT_NOW(a_size_closes_search, size_reg, over_reg)
    // A malformation parks the walker in its failed phase.
    `JMW_ASSERT_NOW(a_failed_parks, failed_reg, phase_reg == PH_FAILED)
    // End of image parks the walker in its done phase.
    `JMW_ASSERT_NOW(a_eoi_parks, end_reg, phase_reg == PH_DONE)
    // A final byte leaves the walker back at the signature check.
    `JMW_ASSERT_NEXT(a_last_restarts, item.fire && item.last, phase_reg == PH_SIG0)

endmodule

### sv/jmw_out_stage.sv
// Result register of the marker walker.
module jmw_out_stage (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  jmw_pkg::result_t result,
    output logic             out_busy,
    output logic             out_valid,
    input  logic             out_stall,
    output logic             recognized,
    output logic             size_found,
    output logic [15:0]      width,
    output logic [15:0]      height,
    output logic             complete
);
    import jmw_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    // The slot is busy while a result waits on a stalled receiver.
    assign out_busy = valid_reg && out_stall;

    always_comb
    begin
        valid_next = out_busy;
        if (load)
        begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result;
        end
    end

    assign out_valid  = valid_reg;
    assign recognized = result_reg.recognized;
    assign size_found = result_reg.size_found;
    assign width      = result_reg.width;
    assign height     = result_reg.height;
    assign complete   = result_reg.complete;

endmodule

### dv/jpeg_marker_walker_core_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for the JPEG marker walker core with a walker predictor.
module jpeg_marker_walker_core_test;
    import jmw_pkg::*;

    // One pending input item: a buffer byte and its final-byte flag.
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } byte_in_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    logic [7:0]  data_byte = 8'h00;
    logic        last_byte = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        recognized;
    logic        size_found;
    logic [15:0] width;
    logic [15:0] height;
    logic        complete;

    byte_in_t   pending_bytes[$];
    result_t    expected_results[$];
    logic [7:0] img_bytes[$];
    byte_in_t   next_item;
    result_t    got_result;

    int errors      = 0;
    bit in_taken    = 1'b0;
    int gap_left    = 0;
    int burst_left  = 0;
    int cycle_count = 0;
    int hold_left   = 0;
    int stall_mode  = 0;
    int mode_left   = 0;
    int stall_phase = 0;
    bit stall_next  = 1'b0;

    // Walker state mirrored by the predictor.
    logic [3:0]  wk_phase       = PH_SIG0;
    logic [15:0] wk_len         = '0;
    logic [15:0] wk_count       = '0;
    logic [7:0]  wk_marker      = '0;
    logic        wk_scan        = 1'b0;
    logic        wk_search_done = 1'b0;
    logic [15:0] wk_height      = '0;
    logic [15:0] wk_width       = '0;
    logic        wk_size_ok     = 1'b0;
    logic        wk_broken      = 1'b0;
    logic        wk_eoi         = 1'b0;
    logic        wk_escape      = 1'b0;

    jpeg_marker_walker_core u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .data_byte  (data_byte),
        .last_byte  (last_byte),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .recognized (recognized),
        .size_found (size_found),
        .width      (width),
        .height     (height),
        .complete   (complete)
    );

    always #4 clk = ~clk;

    // RST0..RST7 share the top five bits 11010.
    function automatic bit restart_code(input logic [7:0] m);
        return m[7:3] == 5'b11010;
    endfunction

    // Cx frame markers, leaving out the C4, C8 and CC codes.
    function automatic bit frame_code(input logic [7:0] m);
        return (m[7:4] == 4'hc) && !((m[1:0] == 2'b00) && (m[3:2] != 2'b00));
    endfunction

    task automatic walker_clear();
        wk_phase       = PH_SIG0;
        wk_len         = '0;
        wk_count       = '0;
        wk_marker      = '0;
        wk_scan        = 1'b0;
        wk_search_done = 1'b0;
        wk_height      = '0;
        wk_width       = '0;
        wk_size_ok     = 1'b0;
        wk_broken      = 1'b0;
        wk_eoi         = 1'b0;
        wk_escape      = 1'b0;
    endtask

    task automatic walker_fail();
        wk_broken      = 1'b1;
        wk_search_done = 1'b1;
        wk_phase       = PH_FAILED;
    endtask

    task automatic walker_marker(input logic [7:0] m);
        if (m == MK_NUL)
        begin
            walker_fail();
        end
        else if (m == MK_EOI)
        begin
            wk_eoi         = 1'b1;
            wk_search_done = 1'b1;
            wk_phase       = PH_DONE;
        end
        else if (m == MK_TEM || restart_code(m))
        begin
            wk_phase = PH_PREFIX;
        end
        else
        begin
            if (m == MK_SOS)
                wk_search_done = 1'b1;
            wk_marker = m;
            wk_phase  = PH_LEN_HI;
        end
    endtask

    task automatic walker_segment_done();
        if (frame_code(wk_marker) && !wk_search_done)
        begin
            if (wk_count >= 16'd5)
                wk_size_ok = 1'b1;
            wk_search_done = 1'b1;
        end
        if (wk_marker == MK_SOS)
        begin
            wk_scan   = 1'b1;
            wk_escape = 1'b0;
            wk_phase  = PH_ENTROPY;
        end
        else
        begin
            wk_phase = PH_PREFIX;
        end
    endtask

    task automatic walker_byte(input logic [7:0] b);
        logic [15:0] full_len;
        case (wk_phase)
            PH_SIG0: wk_phase = (b == MK_FF) ? PH_SIG1 : PH_REJECT;
            PH_SIG1: wk_phase = (b == MK_SOI) ? PH_SIG2 : PH_REJECT;
            PH_SIG2: wk_phase = (b == MK_FF) ? PH_FILL : PH_REJECT;
            PH_PREFIX:
            begin
                if (b == MK_FF)
                    wk_phase = PH_FILL;
                else
                    walker_fail();
            end
            PH_FILL:
            begin
                if (b != MK_FF)
                    walker_marker(b);
            end
            PH_LEN_HI:
            begin
                wk_len   = {b, 8'h00};
                wk_phase = PH_LEN_LO;
            end
            PH_LEN_LO:
            begin
                full_len = wk_len | {8'h00, b};
                if (full_len < LEN_MIN)
                begin
                    walker_fail();
                end
                else
                begin
                    wk_len   = full_len - LEN_MIN;
                    wk_count = '0;
                    if (wk_len == 16'd0)
                        walker_segment_done();
                    else
                        wk_phase = PH_BODY;
                end
            end
            PH_BODY:
            begin
                // Frame header bytes 1..4 carry height then width, big-endian.
                if (frame_code(wk_marker) && !wk_search_done)
                begin
                    case (wk_count)
                        16'd1: wk_height = {b, 8'h00};
                        16'd2: wk_height = wk_height | {8'h00, b};
                        16'd3: wk_width  = {b, 8'h00};
                        16'd4: wk_width  = wk_width | {8'h00, b};
                        default: ;
                    endcase
                end
                wk_count = wk_count + 16'd1;
                wk_len   = wk_len - 16'd1;
                if (wk_len == 16'd0)
                    walker_segment_done();
            end
            PH_ENTROPY:
            begin
                if (!wk_escape)
                begin
                    if (b == MK_FF)
                        wk_escape = 1'b1;
                end
                else if (b == MK_NUL || restart_code(b))
                begin
                    wk_escape = 1'b0;
                end
                else if (b != MK_FF)
                begin
                    wk_escape = 1'b0;
                    walker_marker(b);
                end
            end
            default: ;
        endcase
    endtask

    // Advance the walker by one accepted item; the final byte yields a result.
    task automatic predict_result(input logic [7:0] b, input logic last);
        result_t r;
        logic    recog;
        walker_byte(b);
        if (last)
        begin
            recog = (wk_phase != PH_SIG0) && (wk_phase != PH_SIG1) &&
                    (wk_phase != PH_SIG2) && (wk_phase != PH_REJECT);
            r.recognized = recog;
            r.size_found = recog && wk_size_ok;
            r.width      = (recog && wk_size_ok) ? wk_width : 16'd0;
            r.height     = (recog && wk_size_ok) ? wk_height : 16'd0;
            r.complete   = recog && wk_eoi && wk_scan && !wk_broken;
            expected_results.push_back(r);
            walker_clear();
        end
    endtask

    task automatic check_field(input string tag, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, tag, want, got);
            errors++;
        end
    endtask

    // Marker with its FF prefix; the first one reuses the last signature byte.
    task automatic emit_marker(input logic [7:0] code, input bit first);
        if (!first)
            img_bytes.push_back(MK_FF);
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 2)) img_bytes.push_back(MK_FF);
        img_bytes.push_back(code);
    endtask

    // Length field and body; frame bodies lean toward extreme dimensions.
    task automatic emit_segment(input int body_len, input bit frame);
        logic [15:0] seg_len;
        int          r;
        seg_len = 16'(body_len + 2);
        img_bytes.push_back(seg_len[15:8]);
        img_bytes.push_back(seg_len[7:0]);
        for (int i = 0; i < body_len; i++)
        begin
            r = $urandom_range(0, 5);
            if (frame && i >= 1 && i <= 4 && r == 0)
                img_bytes.push_back(8'h00);
            else if (frame && i >= 1 && i <= 4 && r == 1)
                img_bytes.push_back(8'hff);
            else
                img_bytes.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    // Scan data with stuffed bytes, restarts and fill runs.
    task automatic emit_entropy();
        int r;
        repeat ($urandom_range(0, 10))
        begin
            r = $urandom_range(0, 9);
            if (r == 0)
            begin
                img_bytes.push_back(MK_FF);
                img_bytes.push_back(MK_NUL);
            end
            else if (r == 1)
            begin
                img_bytes.push_back(MK_FF);
                img_bytes.push_back(MK_RST0 + 8'($urandom_range(0, 7)));
            end
            else if (r == 2)
            begin
                img_bytes.push_back(MK_FF);
                img_bytes.push_back(MK_FF);
                img_bytes.push_back(MK_NUL);
            end
            else
            begin
                img_bytes.push_back(8'($urandom_range(0, 254)));
            end
        end
    endtask

    // A buffer: signature, header segments (some with a too-short length), optional scans, EOI, trailing bytes.
    task automatic build_image();
        bit         first;
        int         r;
        logic [7:0] code;
        img_bytes.delete();
        img_bytes.push_back(MK_FF);
        img_bytes.push_back(MK_SOI);
        img_bytes.push_back(MK_FF);
        first = 1'b1;
        repeat ($urandom_range(0, 3))
        begin
            r = $urandom_range(0, 19);
            if (r < 2)
            begin
                emit_marker((r == 0) ? MK_TEM : MK_RST0 + 8'($urandom_range(0, 7)), first);
            end
            else if (r < 7)
            begin
                do code = MK_SOF0 + 8'($urandom_range(0, 15)); while (!frame_code(code));
                emit_marker(code, first);
                emit_segment(($urandom_range(0, 3) == 0) ? $urandom_range(0, 4)
                                                         : $urandom_range(5, 9), 1'b1);
            end
            else if (r < 9)
            begin
                code = (r == 7) ? MK_DHT : (($urandom_range(0, 1) == 0) ? MK_JPG : MK_DAC);
                emit_marker(code, first);
                emit_segment($urandom_range(0, 6), 1'b1);
            end
            else if (r == 9)
            begin
                // Length field below the minimum.
                emit_marker(8'($urandom_range(8'hdb, 8'hfe)), first);
                img_bytes.push_back(8'h00);
                img_bytes.push_back(8'($urandom_range(0, 1)));
            end
            else
            begin
                emit_marker(8'($urandom_range(8'hdb, 8'hfe)), first);
                emit_segment($urandom_range(0, 6), 1'b0);
            end
            first = 1'b0;
        end
        if ($urandom_range(0, 7) != 0)
        begin
            repeat ($urandom_range(1, 2))
            begin
                if (!first && $urandom_range(0, 3) == 0)
                begin
                    emit_marker(MK_DHT, first);
                    emit_segment($urandom_range(0, 4), 1'b0);
                end
                emit_marker(MK_SOS, first);
                first = 1'b0;
                emit_segment($urandom_range(0, 4), 1'b0);
                emit_entropy();
            end
        end
        emit_marker(MK_EOI, first);
        repeat ($urandom_range(0, 3)) img_bytes.push_back(8'($urandom_range(0, 255)));
    endtask

    // Queue the built buffer, flagging its final byte.
    task automatic queue_image();
        byte_in_t it;
        for (int i = 0; i < img_bytes.size(); i++)
        begin
            it.data = img_bytes[i];
            it.last = (i == img_bytes.size() - 1);
            pending_bytes.push_back(it);
        end
    endtask

    // Sender: bursts of items separated by random gaps; a stalled item is held.
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_taken))
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (pending_bytes.size() > 0)
            begin
                next_item = pending_bytes.pop_front();
                in_valid  <= 1'b1;
                data_byte <= next_item.data;
                last_byte <= next_item.last;
                if (burst_left > 0)
                begin
                    burst_left--;
                end
                else
                begin
                    burst_left = $urandom_range(1, 48);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
                end
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
        in_taken = 1'b0;
    end

    // Receiver: stall modes of random duration, plus two long hold-offs.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            cycle_count++;
            if (cycle_count == 500 || cycle_count == 1500)
                hold_left = 300;
            if (hold_left > 0)
            begin
                hold_left--;
                stall_next = 1'b1;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    stall_mode = $urandom_range(0, 2);
                    mode_left  = $urandom_range(20, 120);
                end
                mode_left--;
                stall_phase++;
                case (stall_mode)
                    0:       stall_next = 1'b0;
                    1:       stall_next = 1'($urandom_range(0, 1));
                    default: stall_next = (stall_phase % 3 == 0);
                endcase
            end
            out_stall <= stall_next;
        end
    end

    // Monitor: predict on each accepted input item, check each accepted result.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                predict_result(data_byte, last_byte);
                in_taken = 1'b1;
            end
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual %b %b %0h %0h %b",
                             $time, recognized, size_found, width, height, complete);
                    errors++;
                end
                else
                begin
                    got_result = expected_results.pop_front();
                    check_field("recognized", got_result.recognized, recognized);
                    check_field("size_found", got_result.size_found, size_found);
                    check_field("width", got_result.width, width);
                    check_field("height", got_result.height, height);
                    check_field("complete", got_result.complete, complete);
                end
            end
        end
    end

    // Stimulus, reset and end of run.
    initial
    begin
        int total;
        int kind;
        int cut;
        // Signature failure on a single zero byte.
        img_bytes = '{8'h00};
        queue_image();
        // Buffer that ends inside the signature.
        img_bytes = '{8'hff};
        queue_image();
        // Largest dimensions, stuffed entropy byte, complete buffer.
        img_bytes = '{8'hff, 8'hd8, 8'hff, 8'hc0, 8'h00, 8'h07, 8'h08, 8'hff, 8'hff,
                      8'hff, 8'hff, 8'hff, 8'hda, 8'h00, 8'h02, 8'hff, 8'h00, 8'hff,
                      8'hd9};
        queue_image();
        // Standalone marker then EOI with no scan.
        img_bytes = '{8'hff, 8'hd8, 8'hff, 8'h01, 8'hff, 8'hd9};
        queue_image();

        // Mostly unaltered built buffers, the rest cut short, corrupted or noise.
        total = 0;
        while (total < 1900)
        begin
            build_image();
            kind = $urandom_range(0, 99);
            if (kind >= 60 && kind < 75)
            begin
                cut = $urandom_range(1, img_bytes.size());
                while (img_bytes.size() > cut) void'(img_bytes.pop_back());
            end
            else if (kind >= 75 && kind < 88)
            begin
                repeat ($urandom_range(1, 2))
                    img_bytes[$urandom_range(0, img_bytes.size() - 1)] =
                        8'($urandom_range(0, 255));
            end
            else if (kind >= 88)
            begin
                img_bytes.delete();
                if ($urandom_range(0, 1) == 0)
                begin
                    img_bytes.push_back(MK_FF);
                    img_bytes.push_back(MK_SOI);
                end
                repeat ($urandom_range(1, 12)) img_bytes.push_back(8'($urandom_range(0, 255)));
            end
            total += img_bytes.size();
            queue_image();
        end

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (pending_bytes.size() != 0 || in_valid) @(posedge clk);
        while (expected_results.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("PASS jpeg_marker_walker_core");
        else
            $display("FAIL jpeg_marker_walker_core");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #2000000;
        $display("FAIL jpeg_marker_walker_core");
        $finish;
    end

endmodule
